[sv/bts_pkg.sv]
// Package: shared types and constants for the bilinear texture sampler.
`default_nettype none
package bts_pkg;
  localparam int unsigned MaxSide     = 256;
  localparam int unsigned TexelDepth  = 65536;
  localparam int unsigned ChanBits    = 16;
  localparam int unsigned AddrBits    = $clog2(TexelDepth);
  localparam int unsigned SideBits    = 9;
  localparam int unsigned CoordBits   = 20;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned TexelBits   = 3 * ChanBits;
  localparam int unsigned CfgIdxBits  = 1;
  localparam logic [CfgIdxBits-1:0] RegTexWidth  = 1'b0;
  localparam logic [CfgIdxBits-1:0] RegTexHeight = 1'b1;
  localparam logic OpWrite  = 1'b0;
  localparam logic OpSample = 1'b1;
  localparam logic [ChanBits-1:0] RedOne = ChanBits'(4096);

  typedef struct packed {
    logic                        op;
    logic [15:0]                 texel_addr;
    logic [ChanBits-1:0]         in_red;
    logic [ChanBits-1:0]         in_green;
    logic [ChanBits-1:0]         in_blue;
    logic signed [CoordBits-1:0] u_coord;
    logic signed [CoordBits-1:0] v_coord;
  } in_item_t;

  typedef struct packed {
    logic [ChanBits-1:0] out_red;
    logic [ChanBits-1:0] out_green;
    logic [ChanBits-1:0] out_blue;
    logic                coord_invalid;
  } out_item_t;

  typedef struct packed {
    logic [ChanBits-1:0] r;
    logic [ChanBits-1:0] g;
    logic [ChanBits-1:0] b;
  } texel_t;
endpackage
`default_nettype wire

[sv/bts_lerp.sv]
// Two-stage linear blend of three channels: multiply, register, add and shift.
`default_nettype none
module bts_lerp (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire bts_pkg::texel_t                a,
  input  wire bts_pkg::texel_t                b,
  input  wire logic [bts_pkg::FracBits-1:0]   f,
  output bts_pkg::texel_t                     q
);
  localparam int unsigned PW = bts_pkg::ChanBits + bts_pkg::FracBits + 1;
  logic [PW-1:0] pa [3];
  logic [PW-1:0] pb [3];
  logic [bts_pkg::FracBits:0] inv;
  logic [bts_pkg::ChanBits-1:0] av [3];
  logic [bts_pkg::ChanBits-1:0] bv [3];
  logic [PW:0] sum [3];

  assign inv = (bts_pkg::FracBits+1)'(1 << bts_pkg::FracBits) - {1'b0, f};
  assign av[0] = a.r; assign av[1] = a.g; assign av[2] = a.b;
  assign bv[0] = b.r; assign bv[1] = b.g; assign bv[2] = b.b;

  // products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa[i] <= PW'(av[i] * inv);
        pb[i] <= PW'(bv[i] * f);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) sum[i] = {1'b0, pa[i]} + {1'b0, pb[i]};
  end

  // sum, truncate
  always_ff @(posedge clk) begin
    if (en) begin
      q.r <= sum[0][bts_pkg::FracBits +: bts_pkg::ChanBits];
      q.g <= sum[1][bts_pkg::FracBits +: bts_pkg::ChanBits];
      q.b <= sum[2][bts_pkg::FracBits +: bts_pkg::ChanBits];
    end
  end
endmodule
`default_nettype wire

[sv/bilinear_texture_sampler_unit.sv]
// Top level: pipelined bilinear texture sampler with a four-copy texel store.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+--------------------------
//  input    | in_valid / in_ready           | in_item  (bts_pkg::in_item_t)
//  output   | out_valid / out_ready         | out_item (bts_pkg::out_item_t)
//  config   | cfg_we, cfg_index             | cfg_data (9 bits)
//
// One item per cycle while results are taken; a sample passes through scale
// multiply, address multiply, add, memory read and two blend pairs. Writes
// update all four copies at once, so each neighbor has its own read port.
// Reset clears the valid bits and sets both sizes to 256. The pipeline moves
// as a whole: when the output stage holds an item not taken, every stage holds.
`default_nettype none
module bilinear_texture_sampler_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output      logic                                  in_ready,
  input  wire bts_pkg::in_item_t                     in_item,
  output      logic                                  out_valid,
  input  wire logic                                  out_ready,
  output      bts_pkg::out_item_t                    out_item,
  input  wire logic                                  cfg_we,
  input  wire logic [bts_pkg::CfgIdxBits-1:0]        cfg_index,
  input  wire logic [bts_pkg::SideBits-1:0]          cfg_data
);
  localparam int unsigned NS = 8;
  localparam int unsigned SB = bts_pkg::SideBits;
  localparam int unsigned FB = bts_pkg::FracBits;
  localparam int unsigned AB = bts_pkg::AddrBits;
  localparam int unsigned PB = FB + 1 + SB;

  logic [SB-1:0] tex_width;
  logic [SB-1:0] tex_height;
  logic [SB-1:0] w_c, h_c;
  logic adv;
  logic [NS-1:0] vld;
  logic [NS-1:0] bad;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= SB'(256);
      tex_height <= SB'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bts_pkg::RegTexWidth:  tex_width  <= cfg_data;
        bts_pkg::RegTexHeight: tex_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp sizes
  always_comb begin
    w_c = tex_width;
    h_c = tex_height;
    if (tex_width == '0) w_c = SB'(1);
    else if (tex_width > SB'(bts_pkg::MaxSide)) w_c = SB'(bts_pkg::MaxSide);
    if (tex_height == '0) h_c = SB'(1);
    else if (tex_height > SB'(bts_pkg::MaxSide)) h_c = SB'(bts_pkg::MaxSide);
  end

  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  // texel store writes, four copies
  logic wr_en;
  assign wr_en = in_valid && in_ready && (in_item.op == bts_pkg::OpWrite);
  bts_pkg::texel_t mem0 [bts_pkg::TexelDepth];
  bts_pkg::texel_t mem1 [bts_pkg::TexelDepth];
  bts_pkg::texel_t mem2 [bts_pkg::TexelDepth];
  bts_pkg::texel_t mem3 [bts_pkg::TexelDepth];
  bts_pkg::texel_t wdat;
  assign wdat = '{r: in_item.in_red, g: in_item.in_green, b: in_item.in_blue};

  // stage 0: range check, scale multiply
  logic u_ok, v_ok, s_ok;
  assign u_ok = !in_item.u_coord[bts_pkg::CoordBits-1] &&
                (in_item.u_coord <= $signed(bts_pkg::CoordBits'(1 << FB)));
  assign v_ok = !in_item.v_coord[bts_pkg::CoordBits-1] &&
                (in_item.v_coord <= $signed(bts_pkg::CoordBits'(1 << FB)));
  logic [PB-1:0] su1, sv1;
  logic [SB-1:0] w1;
  always_ff @(posedge clk) begin
    if (adv) begin
      su1 <= PB'(in_item.u_coord[FB:0] * (w_c - SB'(1)));
      sv1 <= PB'(in_item.v_coord[FB:0] * (h_c - SB'(1)));
      w1  <= w_c;
    end
  end
  assign s_ok = u_ok && v_ok;

  // stage 1: integer parts, row base multiplies
  logic [SB-1:0] lu, lv, hu, hv;
  assign lu = su1[FB +: SB];
  assign lv = sv1[FB +: SB];
  assign hu = (su1[FB-1:0] != '0) ? lu + SB'(1) : lu;
  assign hv = (sv1[FB-1:0] != '0) ? lv + SB'(1) : lv;
  logic [AB-1:0] rl2, rh2;
  logic [SB-1:0] lu2, hu2;
  logic [FB-1:0] fu2, fv2;
  always_ff @(posedge clk) begin
    if (adv) begin
      rl2 <= AB'(lv * w1);
      rh2 <= AB'(hv * w1);
      lu2 <= lu; hu2 <= hu;
      fu2 <= su1[FB-1:0];
      fv2 <= sv1[FB-1:0];
    end
  end

  // stage 2: add column to row base
  logic [AB-1:0] a00, a10, a01, a11;
  logic [FB-1:0] fu3, fv3;
  always_ff @(posedge clk) begin
    if (adv) begin
      a00 <= rl2 + AB'(lu2);
      a10 <= rl2 + AB'(hu2);
      a01 <= rh2 + AB'(lu2);
      a11 <= rh2 + AB'(hu2);
      fu3 <= fu2; fv3 <= fv2;
    end
  end

  // stage 3: memory read, registered data
  bts_pkg::texel_t t00, t10, t01, t11;
  logic [FB-1:0] fu4, fv4;
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem0[in_item.texel_addr[AB-1:0]] <= wdat;
      mem1[in_item.texel_addr[AB-1:0]] <= wdat;
      mem2[in_item.texel_addr[AB-1:0]] <= wdat;
      mem3[in_item.texel_addr[AB-1:0]] <= wdat;
    end
    if (adv) begin
      t00 <= mem0[a00];
      t10 <= mem1[a10];
      t01 <= mem2[a01];
      t11 <= mem3[a11];
      fu4 <= fu3; fv4 <= fv3;
    end
  end

  // stages 4-5: blend along u; 6-7: blend along v
  bts_pkg::texel_t top, bot, fin;
  logic [FB-1:0] fv5, fv6;
  bts_lerp u_top (.clk(clk), .en(adv), .a(t00), .b(t10), .f(fu4), .q(top));
  bts_lerp u_bot (.clk(clk), .en(adv), .a(t01), .b(t11), .f(fu4), .q(bot));
  always_ff @(posedge clk) begin
    if (adv) begin
      fv5 <= fv4; fv6 <= fv5;
    end
  end
  bts_lerp u_vert (.clk(clk), .en(adv), .a(top), .b(bot), .f(fv6), .q(fin));

  // valid and invalid-flag pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0],
              in_valid && (in_item.op == bts_pkg::OpSample)};
    end
  end
  always_ff @(posedge clk) begin
    if (adv) bad <= {bad[NS-2:0], !s_ok};
  end

  // output stage
  assign out_valid = vld[NS-1];
  always_comb begin
    if (bad[NS-1]) begin
      out_item = '{out_red: bts_pkg::RedOne, out_green: '0, out_blue: '0,
                   coord_invalid: 1'b1};
    end else begin
      out_item = '{out_red: fin.r, out_green: fin.g, out_blue: fin.b,
                   coord_invalid: 1'b0};
    end
  end

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed during stall");
  // a write item never makes a result
  a_nowr: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_item.op == bts_pkg::OpWrite) |=> !vld[0])
    else $error("write entered pipeline");
  // input ready follows output stage
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("accepted during stall");
endmodule
`default_nettype wire
